@@ sv/cffr_pkg.sv @@
// Shared types and constants of the CAN frame field rewriter.
// Used by every module of the block; has no dependencies of its own.
package cffr_pkg;

  localparam logic [28:0] IdEngineSpeed = 29'h280;
  localparam logic [28:0] IdEngineTemp  = 29'h289;
  localparam logic [28:0] IdEngineStat  = 29'h4E0;

  localparam logic [3:0] RegEnables     = 4'd0;
  localparam logic [3:0] RegRpmOverride = 4'd1;
  localparam logic [3:0] RegRpmOffset   = 4'd2;
  localparam logic [3:0] RegCoolant     = 4'd3;
  localparam logic [3:0] RegOil         = 4'd4;
  localparam logic [3:0] RegBoost       = 4'd5;
  localparam logic [3:0] RegFuel        = 4'd6;
  localparam logic [3:0] RegStatus      = 4'd7;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 17;

  // The queue depth must be a power of two so that the pointers wrap freely.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [1:0] {
    ClsPass,
    ClsSpeed,
    ClsTemp,
    ClsStat
  } frm_class_e;

  typedef struct packed {
    logic [28:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  typedef struct packed {
    frame_t     frame;
    frm_class_e cls;
  } entry_t;

  typedef struct packed {
    logic [2:0]         enables;
    logic [15:0]        rpm_override;
    logic signed [16:0] rpm_offset;
    logic signed [11:0] coolant;
    logic signed [11:0] oil;
    logic [15:0]        boost;
    logic [15:0]        fuel;
    logic [4:0]         status;
  } cfg_t;

endpackage

@@ sv/cffr_regs.sv @@
// Configuration register file of the CAN frame field rewriter.
// Depends on cffr_pkg for register indexes and the cfg_t bundle.
module cffr_regs import cffr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enables      <= 3'd1;
      cfg_q.rpm_override <= 16'd32000;
      cfg_q.rpm_offset   <= 17'sd0;
      cfg_q.coolant      <= 12'sd360;
      cfg_q.oil          <= 12'sd360;
      cfg_q.boost        <= 16'd0;
      cfg_q.fuel         <= 16'd0;
      cfg_q.status       <= 5'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEnables:     cfg_q.enables      <= cfg_data_i[2:0];
        RegRpmOverride: cfg_q.rpm_override <= cfg_data_i[15:0];
        RegRpmOffset:   cfg_q.rpm_offset   <= $signed(cfg_data_i[16:0]);
        RegCoolant:     cfg_q.coolant      <= $signed(cfg_data_i[11:0]);
        RegOil:         cfg_q.oil          <= $signed(cfg_data_i[11:0]);
        RegBoost:       cfg_q.boost        <= cfg_data_i[15:0];
        RegFuel:        cfg_q.fuel         <= cfg_data_i[15:0];
        RegStatus:      cfg_q.status       <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/cffr_front.sv @@
// Front end of the CAN frame field rewriter: accepts frames and classifies them by id.
// Depends on cffr_pkg for the frame and queue entry types.
module cffr_front import cffr_pkg::*; (
  input  logic        push_i,
  input  logic        q_full_i,
  input  logic [28:0] id_i,
  input  logic [3:0]  len_i,
  input  logic [7:0]  b0_i,
  input  logic [7:0]  b1_i,
  input  logic [7:0]  b2_i,
  input  logic [7:0]  b3_i,
  input  logic [7:0]  b4_i,
  input  logic [7:0]  b5_i,
  input  logic [7:0]  b6_i,
  input  logic [7:0]  b7_i,
  output logic        q_push_o,
  output entry_t      q_entry_o
);

  frm_class_e cls;

  always_comb begin
    case (id_i)
      IdEngineSpeed: cls = ClsSpeed;
      IdEngineTemp:  cls = ClsTemp;
      IdEngineStat:  cls = ClsStat;
      default:       cls = ClsPass;
    endcase
  end

  assign q_push_o              = push_i && !q_full_i;
  assign q_entry_o.cls         = cls;
  assign q_entry_o.frame.id    = id_i;
  assign q_entry_o.frame.len   = len_i;
  assign q_entry_o.frame.data  = {b7_i, b6_i, b5_i, b4_i, b3_i, b2_i, b1_i, b0_i};

endmodule

@@ sv/cffr_queue.sv @@
// Short register queue between the front and back ends of the rewriter.
// Depends on cffr_pkg for the entry type and the queue depth.
module cffr_queue import cffr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wr_entry_i,
  input  logic   pop_i,
  output entry_t rd_entry_o,
  output logic   valid_o,
  output logic   full_o
);

  entry_t           mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == (QAw+1)'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

@@ sv/cffr_back.sv @@
// Back end of the rewriter: applies the field rewrites and holds the result register.
// Depends on cffr_pkg for the entry, frame and configuration types.
module cffr_back import cffr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t entry_i,
  input  logic   entry_valid_i,
  output logic   entry_pop_o,
  input  cfg_t   cfg_i,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t frame_o
);

  // Rounded temperature code: floor((2*(q+192)+3)/6), clamped to 0..255.
  function automatic logic [7:0] temp_code(input logic signed [11:0] q);
    logic signed [13:0] v;
    logic [22:0]        prod;
    begin
      v    = ($signed({{2{q[11]}}, q}) <<< 1) + 14'sd387;
      prod = 23'(v[10:0]) * 23'd2731;
      if (v < 0) begin
        temp_code = 8'd0;
      end else if (v >= 14'sd1536) begin
        temp_code = 8'd255;
      end else begin
        temp_code = prod[21:14];
      end
    end
  endfunction

  // Boost raw byte: (mbar + 5) / 10 with rounding, clamped to 255.
  function automatic logic [7:0] boost_code(input logic [15:0] mbar);
    logic [16:0] s;
    logic [24:0] prod;
    begin
      s    = {1'b0, mbar} + 17'd5;
      prod = 25'(s[11:0]) * 25'd6554;
      if (s >= 17'd2560) begin
        boost_code = 8'd255;
      end else begin
        boost_code = prod[23:16];
      end
    end
  endfunction

  logic               valid_q, valid_d;
  frame_t             frame_q;
  frame_t             frame_d;
  logic [15:0]        spd_base;
  logic signed [17:0] spd_sum;
  logic [15:0]        spd_sat;

  assign entry_pop_o = entry_valid_i && (!valid_q || pop_i);
  assign empty_o     = !valid_q;
  assign frame_o     = frame_q;

  always_comb begin
    spd_base = cfg_i.enables[0] ? cfg_i.rpm_override
                                : {entry_i.frame.data[3], entry_i.frame.data[2]};
    spd_sum  = $signed({2'b00, spd_base}) + $signed({cfg_i.rpm_offset[16], cfg_i.rpm_offset});
    if (spd_sum < 0) begin
      spd_sat = 16'd0;
    end else if (spd_sum[16]) begin
      spd_sat = 16'hFFFF;
    end else begin
      spd_sat = spd_sum[15:0];
    end

    frame_d = entry_i.frame;
    case (entry_i.cls)
      ClsSpeed: begin
        frame_d.data[2] = spd_sat[7:0];
        frame_d.data[3] = spd_sat[15:8];
      end
      ClsTemp: begin
        if (cfg_i.enables[1]) begin
          frame_d.data[1]    = temp_code(cfg_i.coolant);
          frame_d.data[2][0] = cfg_i.status[0];
          frame_d.data[2][6] = cfg_i.status[1];
        end
      end
      ClsStat: begin
        if (cfg_i.enables[2]) begin
          frame_d.data[0][0] = cfg_i.status[2];
          frame_d.data[0][3] = cfg_i.status[3];
          frame_d.data[0][4] = cfg_i.status[4];
          frame_d.data[2]    = cfg_i.fuel[7:0];
          frame_d.data[3]    = cfg_i.fuel[15:8];
          frame_d.data[4]    = boost_code(cfg_i.boost);
          frame_d.data[5]    = temp_code(cfg_i.oil);
        end
      end
      default: ;
    endcase

    valid_d = valid_q;
    if (entry_pop_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      frame_q <= frame_d;
    end
  end

endmodule

@@ sv/can_frame_field_rewriter.sv @@
// Top level of the CAN frame field rewriter: front end, queue, back end and registers.
// Depends on cffr_pkg, cffr_regs, cffr_front, cffr_queue and cffr_back.
//
// The block takes one CAN frame per cycle while full is low on a queue-style input
// (push/full) and returns one rewritten frame per input frame, in order, on a
// queue-style output (empty/pop). A frame passes first into the four-entry queue
// behind the classifier and then through the rewrite into the output register.
// Sustained rate is one frame per cycle while the output is popped, set by the single
// rewrite stage in the back end. Configuration registers are written through
// the cfg channel, which is always ready; write them only while no frame is in
// flight.
module can_frame_field_rewriter import cffr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [28:0]          in_id_i,
  input  logic [3:0]           in_len_i,
  input  logic [7:0]           in_b0_i,
  input  logic [7:0]           in_b1_i,
  input  logic [7:0]           in_b2_i,
  input  logic [7:0]           in_b3_i,
  input  logic [7:0]           in_b4_i,
  input  logic [7:0]           in_b5_i,
  input  logic [7:0]           in_b6_i,
  input  logic [7:0]           in_b7_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [28:0]          out_id_o,
  output logic [3:0]           out_len_o,
  output logic [7:0]           out_b0_o,
  output logic [7:0]           out_b1_o,
  output logic [7:0]           out_b2_o,
  output logic [7:0]           out_b3_o,
  output logic [7:0]           out_b4_o,
  output logic [7:0]           out_b5_o,
  output logic [7:0]           out_b6_o,
  output logic [7:0]           out_b7_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t   cfg;
  logic   q_push;
  entry_t q_wr_entry;
  logic   q_pop;
  entry_t q_rd_entry;
  logic   q_valid;
  logic   q_full;
  frame_t out_frame;

  assign full = q_full;

  cffr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cffr_front u_front (
    .push_i    (push),
    .q_full_i  (q_full),
    .id_i      (in_id_i),
    .len_i     (in_len_i),
    .b0_i      (in_b0_i),
    .b1_i      (in_b1_i),
    .b2_i      (in_b2_i),
    .b3_i      (in_b3_i),
    .b4_i      (in_b4_i),
    .b5_i      (in_b5_i),
    .b6_i      (in_b6_i),
    .b7_i      (in_b7_i),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  cffr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .wr_entry_i (q_wr_entry),
    .pop_i      (q_pop),
    .rd_entry_o (q_rd_entry),
    .valid_o    (q_valid),
    .full_o     (q_full)
  );

  cffr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (q_rd_entry),
    .entry_valid_i (q_valid),
    .entry_pop_o   (q_pop),
    .cfg_i         (cfg),
    .pop_i         (pop),
    .empty_o       (empty),
    .frame_o       (out_frame)
  );

  assign out_id_o  = out_frame.id;
  assign out_len_o = out_frame.len;
  assign out_b0_o  = out_frame.data[0];
  assign out_b1_o  = out_frame.data[1];
  assign out_b2_o  = out_frame.data[2];
  assign out_b3_o  = out_frame.data[3];
  assign out_b4_o  = out_frame.data[4];
  assign out_b5_o  = out_frame.data[5];
  assign out_b6_o  = out_frame.data[6];
  assign out_b7_o  = out_frame.data[7];

endmodule

@@ dv/frame_rewrite_checker.sv @@
// Checker for the CAN frame field rewriter: watches the frame, result and register channels.
// Predicts every forwarded frame and compares it field by field with what the block returns.
// Depends on cffr_pkg for the frame and register types and the register indexes.
module frame_rewrite_checker import cffr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic [28:0]          in_id_i,
  input  logic [3:0]           in_len_i,
  input  logic [7:0]           in_b0_i,
  input  logic [7:0]           in_b1_i,
  input  logic [7:0]           in_b2_i,
  input  logic [7:0]           in_b3_i,
  input  logic [7:0]           in_b4_i,
  input  logic [7:0]           in_b5_i,
  input  logic [7:0]           in_b6_i,
  input  logic [7:0]           in_b7_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [28:0]          out_id_o,
  input  logic [3:0]           out_len_o,
  input  logic [7:0]           out_b0_o,
  input  logic [7:0]           out_b1_o,
  input  logic [7:0]           out_b2_o,
  input  logic [7:0]           out_b3_o,
  input  logic [7:0]           out_b4_o,
  input  logic [7:0]           out_b5_o,
  input  logic [7:0]           out_b6_o,
  input  logic [7:0]           out_b7_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   fail_count_o,
  output int                   frames_due_o
);

  cfg_t   settings;
  frame_t frames_due[$];

  function automatic logic [7:0] temp_raw_code(input logic signed [11:0] q);
    int v;
    v = 2 * (int'(q) + 192) + 3;
    if (v < 0) begin
      return 8'd0;
    end
    v = v / 6;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic frame_t rewrite_frame(input frame_t f, input cfg_t c);
    frame_t      r;
    int          spd;
    int unsigned bst;
    r = f;
    case (f.id)
      IdEngineSpeed: begin
        spd = c.enables[0] ? int'(c.rpm_override) : int'({f.data[3], f.data[2]});
        spd = spd + int'($signed(c.rpm_offset));
        if (spd < 0) begin
          spd = 0;
        end
        if (spd > 65535) begin
          spd = 65535;
        end
        r.data[2] = spd[7:0];
        r.data[3] = spd[15:8];
      end
      IdEngineTemp: begin
        if (c.enables[1]) begin
          r.data[1]    = temp_raw_code(c.coolant);
          r.data[2][0] = c.status[0];
          r.data[2][6] = c.status[1];
        end
      end
      IdEngineStat: begin
        if (c.enables[2]) begin
          bst          = (int'(c.boost) + 5) / 10;
          r.data[0][0] = c.status[2];
          r.data[0][3] = c.status[3];
          r.data[0][4] = c.status[4];
          r.data[2]    = c.fuel[7:0];
          r.data[3]    = c.fuel[15:8];
          r.data[4]    = (bst > 255) ? 8'd255 : bst[7:0];
          r.data[5]    = temp_raw_code(c.oil);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (fail_count_o < 10) begin
        $display("mismatch on %s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t offered;
    frame_t seen;
    frame_t want;
    if (!rst_ni) begin
      settings = '{enables: 3'd1, rpm_override: 16'd32000, rpm_offset: '0,
                   coolant: 12'sd360, oil: 12'sd360, boost: '0, fuel: '0, status: '0};
      frames_due.delete();
      fail_count_o = 0;
    end else begin
      if (pop && !empty) begin
        seen.id   = out_id_o;
        seen.len  = out_len_o;
        seen.data = {out_b7_o, out_b6_o, out_b5_o, out_b4_o,
                     out_b3_o, out_b2_o, out_b1_o, out_b0_o};
        if (frames_due.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("result transfer with no frame waiting: id 0x%0h", seen.id);
          end
          fail_count_o++;
        end else begin
          want = frames_due.pop_front();
          check_field("id", want.id, seen.id);
          check_field("len", want.len, seen.len);
          for (int i = 0; i < 8; i++) begin
            check_field($sformatf("byte %0d", i), want.data[i], seen.data[i]);
          end
        end
      end
      if (push && !full) begin
        offered.id   = in_id_i;
        offered.len  = in_len_i;
        offered.data = {in_b7_i, in_b6_i, in_b5_i, in_b4_i,
                        in_b3_i, in_b2_i, in_b1_i, in_b0_i};
        frames_due.push_back(rewrite_frame(offered, settings));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegEnables:     settings.enables      = cfg_data_i[2:0];
          RegRpmOverride: settings.rpm_override = cfg_data_i[15:0];
          RegRpmOffset:   settings.rpm_offset   = cfg_data_i[16:0];
          RegCoolant:     settings.coolant      = cfg_data_i[11:0];
          RegOil:         settings.oil          = cfg_data_i[11:0];
          RegBoost:       settings.boost        = cfg_data_i[15:0];
          RegFuel:        settings.fuel         = cfg_data_i[15:0];
          RegStatus:      settings.status       = cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
    frames_due_o = frames_due.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the CAN frame field rewriter testbench: clock, reset, frames, register writes, verdict.
// Depends on cffr_pkg, can_frame_field_rewriter and frame_rewrite_checker.
module testbench;
  import cffr_pkg::*;

  localparam int LimitCycles      = 400000;
  localparam int RandomSegments   = 12;
  localparam int FramesPerSegment = 96;
  localparam int HoldCycles       = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [28:0]          in_id_i;
  logic [3:0]           in_len_i;
  logic [7:0]           in_b0_i;
  logic [7:0]           in_b1_i;
  logic [7:0]           in_b2_i;
  logic [7:0]           in_b3_i;
  logic [7:0]           in_b4_i;
  logic [7:0]           in_b5_i;
  logic [7:0]           in_b6_i;
  logic [7:0]           in_b7_i;
  logic                 empty;
  logic                 pop;
  logic [28:0]          out_id_o;
  logic [3:0]           out_len_o;
  logic [7:0]           out_b0_o;
  logic [7:0]           out_b1_o;
  logic [7:0]           out_b2_o;
  logic [7:0]           out_b3_o;
  logic [7:0]           out_b4_o;
  logic [7:0]           out_b5_o;
  logic [7:0]           out_b6_o;
  logic [7:0]           out_b7_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int fail_count;
  int frames_due;
  int idle_pct;
  int stall_pct;
  bit hold_req;

  can_frame_field_rewriter dut (.*);

  frame_rewrite_checker u_checker (.*, .fail_count_o(fail_count), .frames_due_o(frames_due));

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL can_frame_field_rewriter");
    $finish;
  end

  // The result side; a requested hold-off is counted out here.
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_frame(input logic [28:0] id, input logic [3:0] len,
                            input logic [63:0] bytes);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    in_id_i  <= id;
    in_len_i <= len;
    in_b0_i  <= bytes[7:0];
    in_b1_i  <= bytes[15:8];
    in_b2_i  <= bytes[23:16];
    in_b3_i  <= bytes[31:24];
    in_b4_i  <= bytes[39:32];
    in_b5_i  <= bytes[47:40];
    in_b6_i  <= bytes[55:48];
    in_b7_i  <= bytes[63:56];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] bytes;
    case ($urandom_range(0, 7))
      0, 1:    id = IdEngineSpeed;
      2, 3:    id = IdEngineTemp;
      4, 5:    id = IdEngineStat;
      6:       id = 29'($urandom);
      default: id = ($urandom_range(0, 1) ? IdEngineSpeed : IdEngineStat)
                    ^ (29'd1 << $urandom_range(0, 28));
    endcase
    len   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
    bytes = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      bytes[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    send_frame(id, len, bytes);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes every register, then one index beyond the last, which must change nothing.
  task automatic write_settings(input logic [16:0] en, input logic [16:0] ovr,
                                input logic [16:0] ofs, input logic [16:0] cool,
                                input logic [16:0] oil, input logic [16:0] bst,
                                input logic [16:0] fuel, input logic [16:0] stat);
    write_reg(RegEnables, en);
    write_reg(RegRpmOverride, ovr);
    write_reg(RegRpmOffset, ofs);
    write_reg(RegCoolant, cool);
    write_reg(RegOil, oil);
    write_reg(RegBoost, bst);
    write_reg(RegFuel, fuel);
    write_reg(RegStatus, stat);
    write_reg(4'(8 + $urandom_range(0, 7)), 17'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [16:0] en;
    logic [16:0] ofs;
    logic [16:0] cool;
    logic [16:0] oil;
    logic [16:0] bst;
    en   = $urandom_range(0, 1) ? (17'($urandom) | 17'h7) : 17'($urandom);
    ofs  = $urandom_range(0, 1) ? 17'($urandom_range(0, 8000) - 4000) : 17'($urandom);
    cool = $urandom_range(0, 1) ? 17'($urandom_range(0, 2048) - 1024) : 17'($urandom);
    oil  = $urandom_range(0, 1) ? 17'($urandom_range(0, 2048) - 1024) : 17'($urandom);
    bst  = $urandom_range(0, 1) ? 17'($urandom_range(0, 3000)) : 17'($urandom);
    write_settings(en, 17'($urandom), ofs, cool, oil, bst, 17'($urandom), 17'($urandom));
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (frames_due != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic settings_max();
    write_settings(17'h7, 17'hFFFF, 17'h0FFFF, 17'h7FF, 17'h7FF, 17'hFFFF, 17'hFFFF, 17'h1F);
  endtask

  task automatic settings_min();
    write_settings(17'h0, 17'h0, 17'h10000, 17'h800, 17'h800, 17'h0, 17'h0, 17'h0);
  endtask

  initial begin
    int seg;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_id_i     <= '0;
    in_len_i    <= '0;
    in_b0_i     <= '0;
    in_b1_i     <= '0;
    in_b2_i     <= '0;
    in_b3_i     <= '0;
    in_b4_i     <= '0;
    in_b5_i     <= '0;
    in_b6_i     <= '0;
    in_b7_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: only the speed override is on.
    send_frame(IdEngineSpeed, 4'd8, 64'h8877_6655_4433_2211);
    send_frame(29'h0, 4'd0, 64'h0);
    send_frame(29'h1FFF_FFFF, 4'd15, '1);
    send_frame(IdEngineTemp, 4'd8, '1);
    send_frame(IdEngineStat, 4'd8, '1);
    send_frame(29'h1000_0280, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(29'h281, 4'd8, 64'hFEDC_BA98_7654_3210);

    settle();
    settings_max();
    send_frame(IdEngineSpeed, 4'd8, 64'h0);
    send_frame(IdEngineTemp, 4'd8, 64'h0);
    send_frame(IdEngineTemp, 4'd8, '1);
    send_frame(IdEngineStat, 4'd8, 64'h0);
    send_frame(IdEngineStat, 4'd9, '1);

    settle();
    settings_min();
    send_frame(IdEngineSpeed, 4'd2, 64'h0000_0000_FFFF_0000);
    send_frame(IdEngineSpeed, 4'd8, 64'h0);
    send_frame(IdEngineTemp, 4'd8, '1);
    send_frame(IdEngineStat, 4'd8, '1);

    settle();
    write_settings(17'h6, 17'd1234, 17'd1, 17'd0, 17'h1FF42, 17'd2545, 17'h1234, 17'h0A);
    send_frame(IdEngineSpeed, 4'd8, 64'h0000_0000_FFFF_0000);
    send_frame(IdEngineSpeed, 4'd8, 64'h0000_0000_1234_0000);
    send_frame(IdEngineTemp, 4'd8, 64'h5555_5555_5555_5555);
    send_frame(IdEngineStat, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);

    for (seg = 0; seg < RandomSegments; seg++) begin
      settle();
      if (seg == 4) begin
        settings_max();
      end else if (seg == 8) begin
        settings_min();
      end else begin
        random_settings();
      end
      case (seg % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 64;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 64;
        end
        default: begin
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      if (seg % 5 == 0) begin
        hold_req = 1'b1;
      end
      repeat (FramesPerSegment) send_random_frame();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS can_frame_field_rewriter");
    end else begin
      $display("FAIL can_frame_field_rewriter");
    end
    $finish;
  end

endmodule
